// ----- hw/rtl/ivt_pkg.sv -----
package ivt_pkg;

    localparam int KIND_W         = 3;
    localparam int SLOT_W         = 5;
    localparam int HANDLER_IN_W   = 16;
    localparam int STATUS_W       = 3;
    localparam int IN_TDATA_W     = 32;
    localparam int OUT_TDATA_W    = 24;

    localparam int SLOT_COUNT_DEF    = 32;
    localparam int HANDLER_WIDTH_DEF = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUERY   = 3'd0,
        KIND_ATTACH  = 3'd1,
        KIND_REPLACE = 3'd2,
        KIND_MODIFY  = 3'd3,
        KIND_DETACH  = 3'd4,
        KIND_ENABLE  = 3'd5,
        KIND_DISABLE = 3'd6,
        KIND_TRIGGER = 3'd7
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SUCCESS    = 3'd0,
        ST_OCCUPIED   = 3'd1,
        ST_NOT_LOADED = 3'd2,
        ST_IMMUTABLE  = 3'd3,
        ST_DISABLED   = 3'd4
    } status_t;

    typedef struct packed {
        logic loaded;
        logic enabled;
        logic locked;
    } flags_t;

    typedef struct packed {
        logic   wr_flags;
        flags_t flags;
        logic   wr_handler;
    } update_t;

    typedef struct packed {
        status_t status;
        logic    dispatch;
    } result_t;

endpackage

// ----- hw/rtl/ivt_ram.sv -----
module ivt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/ivt_exec.sv -----
module ivt_exec (
    input  ivt_pkg::kind_t   kind,
    input  logic             in_range,
    input  logic             lock,
    input  ivt_pkg::flags_t  cur,
    output ivt_pkg::update_t upd,
    output ivt_pkg::result_t res
);

    import ivt_pkg::*;

    always_comb
    begin
        upd            = '0;
        res.status     = ST_NOT_LOADED;
        res.dispatch   = 1'b0;
        if (in_range)
        begin
            case (kind)
                KIND_QUERY:
                begin
                    res.status = cur.loaded ? ST_OCCUPIED : ST_NOT_LOADED;
                end
                KIND_ATTACH:
                begin
                    if (cur.loaded)
                    begin
                        res.status = ST_OCCUPIED;
                    end
                    else
                    begin
                        upd.wr_flags   = 1'b1;
                        upd.flags      = '{loaded: 1'b1, enabled: 1'b1, locked: lock};
                        upd.wr_handler = 1'b1;
                        res.status     = ST_SUCCESS;
                    end
                end
                KIND_REPLACE:
                begin
                    upd.wr_flags   = 1'b1;
                    upd.flags      = '{loaded: 1'b1, enabled: 1'b1, locked: lock};
                    upd.wr_handler = 1'b1;
                    res.status     = ST_SUCCESS;
                end
                KIND_MODIFY:
                begin
                    if (cur.locked)
                    begin
                        res.status = ST_IMMUTABLE;
                    end
                    else if (cur.loaded)
                    begin
                        upd.wr_handler = 1'b1;
                        res.status     = ST_SUCCESS;
                    end
                end
                KIND_DETACH:
                begin
                    if (cur.loaded)
                    begin
                        // handler id left stale: never read while unloaded
                        upd.wr_flags = 1'b1;
                        upd.flags    = '0;
                        res.status   = ST_SUCCESS;
                    end
                end
                KIND_ENABLE, KIND_DISABLE:
                begin
                    if (cur.loaded)
                    begin
                        upd.wr_flags = 1'b1;
                        upd.flags    = '{loaded: 1'b1, enabled: (kind == KIND_ENABLE),
                                         locked: cur.locked};
                        res.status   = ST_SUCCESS;
                    end
                end
                KIND_TRIGGER:
                begin
                    if (cur.loaded)
                    begin
                        if (cur.enabled)
                        begin
                            res.dispatch = 1'b1;
                            res.status   = ST_SUCCESS;
                        end
                        else
                        begin
                            res.status = ST_DISABLED;
                        end
                    end
                end
                default:
                begin
                    res.status = ST_NOT_LOADED;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/interrupt_vector_table_top.sv -----
// Interrupt vector table: SLOT_COUNT slots, each with loaded, enable and lock
// bits and a handler id.
// Input stream (s_axis_*): one word per operation on one slot. Output stream
// (m_axis_*): exactly one result word per input word, in order, carrying the
// status code and, for a successful trigger, the dispatched handler id.
// An accepted word goes into the input register, then through the table access
// into the result register.
// Throughput: one word per cycle unless the output stalls; each word is a single
// read-modify-write of one slot, the flag bits in flops and the handler ids in a
// RAM whose write from one word is forwarded to the word read in the same cycle.
// Reset clears all loaded/enable/lock bits at once; the block takes words in
// the first cycle after reset. Handler RAM needs no clearing.
// When the receiver holds m_axis_tready low the result register holds, the
// input register fills behind it, and s_axis_tready then drops; no word is
// lost or duplicated.
module interrupt_vector_table_top #(
    parameter int SLOT_COUNT    = ivt_pkg::SLOT_COUNT_DEF,
    parameter int HANDLER_WIDTH = ivt_pkg::HANDLER_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] kind, [7:3] slot, [23:8] handler, [24] lock, [31:25] zero
    input  logic [ivt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] status, [3] dispatch_valid, [19:4] dispatch_handler, [23:20] zero
    output logic [ivt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import ivt_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int HW = HANDLER_WIDTH;

    // input register
    logic              s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [AW-1:0]     s1_idx_reg;
    logic              s1_range_reg;
    logic [HW-1:0]     s1_handler_reg;
    logic              s1_lock_reg;

    // result register
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic                    out_dv_reg;
    logic [HANDLER_IN_W-1:0] out_dh_reg;

    // table flags
    logic [SLOT_COUNT-1:0] loaded_reg, loaded_next;
    logic [SLOT_COUNT-1:0] enabled_reg, enabled_next;
    logic [SLOT_COUNT-1:0] locked_reg, locked_next;

    // forward of a handler write to the word read in the same cycle
    logic          byp_valid_reg;
    logic [AW-1:0] byp_idx_reg;
    logic [HW-1:0] byp_handler_reg;

    logic          in_fire;
    logic          s1_advance;
    logic          commit;
    logic [SLOT_W-1:0]       in_slot;
    logic [SW-1:0]           in_slot_wide;
    logic [AW-1:0]           in_idx;
    logic                    in_range;
    logic [31:0]             in_handler32;
    logic [HW-1:0]           ram_rd_data;
    logic [HW-1:0]           stored_handler;
    logic [31:0]             stored32;
    flags_t                  cur_flags;
    update_t                 upd;
    result_t                 res;

    assign in_slot      = s_axis_tdata[7:3];
    assign in_slot_wide = SW'(in_slot);
    assign in_idx       = in_slot_wide[AW-1:0];
    assign in_range     = (32'(in_slot) < 32'(SLOT_COUNT));
    assign in_handler32 = 32'(s_axis_tdata[23:8]);

    assign s1_advance    = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign commit        = s1_valid_reg && s1_advance;

    assign cur_flags.loaded  = loaded_reg[s1_idx_reg];
    assign cur_flags.enabled = enabled_reg[s1_idx_reg];
    assign cur_flags.locked  = locked_reg[s1_idx_reg];

    ivt_exec u_exec (
        .kind     (kind_t'(s1_kind_reg)),
        .in_range (s1_range_reg),
        .lock     (s1_lock_reg),
        .cur      (cur_flags),
        .upd      (upd),
        .res      (res)
    );

    ivt_ram #(
        .WIDTH (HW),
        .DEPTH (SLOT_COUNT)
    ) u_handler_ram (
        .clk     (clk),
        .wr_en   (commit && upd.wr_handler),
        .wr_addr (s1_idx_reg),
        .wr_data (s1_handler_reg),
        .rd_en   (in_fire),
        .rd_addr (in_idx),
        .rd_data (ram_rd_data)
    );

    assign stored_handler = (byp_valid_reg && (byp_idx_reg == s1_idx_reg)) ?
                            byp_handler_reg : ram_rd_data;
    assign stored32       = 32'(stored_handler);

    always_comb
    begin
        loaded_next  = loaded_reg;
        enabled_next = enabled_reg;
        locked_next  = locked_reg;
        if (commit && upd.wr_flags)
        begin
            loaded_next[s1_idx_reg]  = upd.flags.loaded;
            enabled_next[s1_idx_reg] = upd.flags.enabled;
            locked_next[s1_idx_reg]  = upd.flags.locked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
            loaded_reg    <= '0;
            enabled_reg   <= '0;
            locked_reg    <= '0;
        end
        else
        begin
            loaded_reg  <= loaded_next;
            enabled_reg <= enabled_next;
            locked_reg  <= locked_next;
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (in_fire)
            begin
                byp_valid_reg <= commit && upd.wr_handler;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg     <= s_axis_tdata[2:0];
            s1_idx_reg      <= in_idx;
            s1_range_reg    <= in_range;
            s1_handler_reg  <= in_handler32[HW-1:0];
            s1_lock_reg     <= s_axis_tdata[24];
            byp_idx_reg     <= s1_idx_reg;
            byp_handler_reg <= s1_handler_reg;
        end
        if (commit)
        begin
            out_status_reg <= res.status;
            out_dv_reg     <= res.dispatch;
            out_dh_reg     <= res.dispatch ? stored32[HANDLER_IN_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_dh_reg, out_dv_reg, out_status_reg};

endmodule

// ----- tb/tb_interrupt_vector_table_top.sv -----
module tb_interrupt_vector_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ivt_pkg::*;

    localparam int TABLE_SLOTS  = 32;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_OPS   = 250;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        status_t     status;
        logic        dispatch_valid;
        logic [15:0] dispatch_handler;
    } ivt_result_t;

    // Shadow of the slot table; works out the result word due for every
    // accepted operation.
    class ivt_scoreboard;
        bit          slot_loaded [TABLE_SLOTS];
        bit          slot_enabled[TABLE_SLOTS];
        bit          slot_locked [TABLE_SLOTS];
        logic [15:0] slot_handler[TABLE_SLOTS];
        ivt_result_t due_results[$];
        int          mismatches;
        int          ops_seen;
        int          dispatches;
        int          status_seen[5];

        function new();
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                slot_loaded[i]  = 1'b0;
                slot_enabled[i] = 1'b0;
                slot_locked[i]  = 1'b0;
                slot_handler[i] = '0;
            end
            mismatches = 0;
            ops_seen   = 0;
            dispatches = 0;
            for (int i = 0; i < 5; i++)
                status_seen[i] = 0;
        endfunction

        function void clear_entry(int s);
            slot_loaded[s]  = 1'b0;
            slot_enabled[s] = 1'b0;
            slot_locked[s]  = 1'b0;
            slot_handler[s] = '0;
        endfunction

        function status_t load_entry(int s, logic [15:0] handler, logic lock);
            if (slot_loaded[s])
                return ST_OCCUPIED;
            slot_loaded[s]  = 1'b1;
            slot_enabled[s] = 1'b1;
            slot_locked[s]  = lock;
            slot_handler[s] = handler;
            return ST_SUCCESS;
        endfunction

        function void note_op(kind_t kind, logic [4:0] slot, logic [15:0] handler,
                              logic lock);
            ivt_result_t r;
            int s;
            s = int'(slot);
            r.status           = ST_NOT_LOADED;
            r.dispatch_valid   = 1'b0;
            r.dispatch_handler = '0;
            if (s < TABLE_SLOTS)
            begin
                case (kind)
                    KIND_QUERY:
                        r.status = slot_loaded[s] ? ST_OCCUPIED : ST_NOT_LOADED;
                    KIND_ATTACH:
                        r.status = load_entry(s, handler, lock);
                    KIND_REPLACE:
                    begin
                        clear_entry(s);
                        r.status = load_entry(s, handler, lock);
                    end
                    KIND_MODIFY:
                    begin
                        // lock is checked ahead of loaded
                        if (slot_locked[s])
                            r.status = ST_IMMUTABLE;
                        else if (slot_loaded[s])
                        begin
                            slot_handler[s] = handler;
                            r.status = ST_SUCCESS;
                        end
                    end
                    KIND_DETACH:
                    begin
                        if (slot_loaded[s])
                        begin
                            clear_entry(s);
                            r.status = ST_SUCCESS;
                        end
                    end
                    KIND_ENABLE, KIND_DISABLE:
                    begin
                        if (slot_loaded[s])
                        begin
                            slot_enabled[s] = (kind == KIND_ENABLE);
                            r.status = ST_SUCCESS;
                        end
                    end
                    default:
                    begin
                        if (slot_loaded[s])
                        begin
                            if (slot_enabled[s])
                            begin
                                r.status           = ST_SUCCESS;
                                r.dispatch_valid   = 1'b1;
                                r.dispatch_handler = slot_handler[s];
                                dispatches++;
                            end
                            else
                                r.status = ST_DISABLED;
                        end
                    end
                endcase
            end
            status_seen[int'(r.status)]++;
            ops_seen++;
            due_results.push_back(r);
        endfunction

        function void flag_failure(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            ivt_result_t r;
            if (due_results.size() == 0)
            begin
                flag_failure($sformatf("result word %h with nothing outstanding", word));
                return;
            end
            r = due_results.pop_front();
            if (word[2:0] !== r.status || word[3] !== r.dispatch_valid ||
                word[19:4] !== r.dispatch_handler)
                flag_failure($sformatf(
                    {"expected status %0d dispatch %0b handler %h, ",
                     "got status %0d dispatch %0b handler %h"},
                    r.status, r.dispatch_valid, r.dispatch_handler,
                    word[2:0], word[3], word[19:4]));
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    ivt_scoreboard board = new();
    int src_gap_pct     = 0;
    int sink_stall_pct  = 0;
    int cycle_count     = 0;

    interrupt_vector_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check on handshake, then pick next tready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_op(kind_t kind, logic [4:0] slot, logic [15:0] handler, logic lock);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, lock, handler, slot, kind};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_op(kind, slot, handler, lock);
    endtask

    task automatic send_random_ops(int count);
        logic [4:0]  hot_slots[4];
        logic [4:0]  slot;
        logic [15:0] handler;
        int          pick;
        hot_slots[0] = 5'd0;
        hot_slots[1] = 5'd7;
        hot_slots[2] = 5'd24;
        hot_slots[3] = 5'd31;
        for (int i = 0; i < count; i++)
        begin
            // mostly a few busy slots so attach/trigger/modify chains build up
            if ($urandom_range(99) < 75)
                slot = hot_slots[$urandom_range(3)];
            else
                slot = 5'($urandom_range(TABLE_SLOTS - 1));
            pick = $urandom_range(9);
            if (pick == 0)
                handler = 16'h0000;
            else if (pick == 1)
                handler = 16'hffff;
            else
                handler = 16'($urandom_range(16'hffff));
            send_op(kind_t'($urandom_range(7)), slot, handler, ($urandom_range(3) == 0));
        end
    endtask

    // the last word stays on the bus after its handshake, so drop tvalid first
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sweep
        send_op(KIND_QUERY,   5'd0,  16'h0000, 1'b0);
        send_op(KIND_ATTACH,  5'd0,  16'hffff, 1'b0);
        send_op(KIND_ATTACH,  5'd0,  16'h1111, 1'b1);
        send_op(KIND_QUERY,   5'd0,  16'h0000, 1'b0);
        send_op(KIND_TRIGGER, 5'd0,  16'h0000, 1'b0);
        send_op(KIND_DISABLE, 5'd0,  16'h0000, 1'b0);
        send_op(KIND_TRIGGER, 5'd0,  16'h0000, 1'b0);
        send_op(KIND_ENABLE,  5'd0,  16'h0000, 1'b0);
        send_op(KIND_MODIFY,  5'd0,  16'h0000, 1'b1);
        send_op(KIND_TRIGGER, 5'd0,  16'hffff, 1'b1);
        send_op(KIND_ATTACH,  5'd31, 16'ha5a5, 1'b1);
        send_op(KIND_MODIFY,  5'd31, 16'h0001, 1'b0);
        send_op(KIND_TRIGGER, 5'd31, 16'h0000, 1'b0);
        send_op(KIND_REPLACE, 5'd31, 16'h5a5a, 1'b0);
        send_op(KIND_MODIFY,  5'd31, 16'h1234, 1'b0);
        send_op(KIND_TRIGGER, 5'd31, 16'h0000, 1'b0);
        send_op(KIND_DETACH,  5'd31, 16'h0000, 1'b0);
        send_op(KIND_DETACH,  5'd31, 16'h0000, 1'b0);
        send_op(KIND_MODIFY,  5'd31, 16'hffff, 1'b0);
        send_op(KIND_ENABLE,  5'd17, 16'h0000, 1'b0);
        send_op(KIND_DISABLE, 5'd17, 16'h0000, 1'b0);
        send_op(KIND_TRIGGER, 5'd17, 16'h0000, 1'b0);
        send_op(KIND_REPLACE, 5'd10, 16'hffff, 1'b1);
        send_op(KIND_MODIFY,  5'd10, 16'h0000, 1'b0);
        // detach ignores the lock
        send_op(KIND_DETACH,  5'd10, 16'h0000, 1'b0);
        drain();

        src_gap_pct = 0;  sink_stall_pct = 0;
        send_random_ops(RANDOM_OPS);
        drain();
        src_gap_pct = 45; sink_stall_pct = 0;
        send_random_ops(RANDOM_OPS);
        drain();
        src_gap_pct = 0;  sink_stall_pct = 45;
        send_random_ops(RANDOM_OPS);
        drain();
        src_gap_pct = 30; sink_stall_pct = 30;
        send_random_ops(RANDOM_OPS);

        drain();
        repeat (10) @(posedge clk);

        $display("Ran %0d table operations under four handshake patterns, %0d dispatches.",
                 board.ops_seen, board.dispatches);
        $display({"Status mix: success %0d, occupied %0d, not loaded %0d, ",
                  "immutable %0d, disabled %0d."},
                 board.status_seen[0], board.status_seen[1], board.status_seen[2],
                 board.status_seen[3], board.status_seen[4]);
        if (board.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ivt_pkg.sv
hw/rtl/ivt_ram.sv
hw/rtl/ivt_exec.sv
hw/rtl/interrupt_vector_table_top.sv
tb/tb_interrupt_vector_table_top.sv
